/* design/page_block_chain_scrambler_unit_defines.svh */
// Assertion macros for the page block chain scrambler.
`ifndef PAGE_BLOCK_CHAIN_SCRAMBLER_UNIT_DEFINES_SVH
`define PAGE_BLOCK_CHAIN_SCRAMBLER_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define PBCS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pbcs: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define PBCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pbcs: next-cycle check failed");

`endif

/* design/pbcs_pkg.sv */
// Package: constants and types shared by the page block chain scrambler.
package pbcs_pkg;

  localparam int BLOCKS_PER_PAGE = 32;
  localparam int CNT_W = $clog2(BLOCKS_PER_PAGE);

  localparam int WORD_W = 32;
  localparam int IDX_W = 5;
  localparam int IN_DATA_W = 5 * WORD_W;
  localparam int OUT_RAW_W = 4 * WORD_W + 2 * IDX_W;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic {
    REG_SCRAMBLE_CODE   = 1'b0,
    REG_DESCRAMBLE_MODE = 1'b1
  } pbcs_reg_t;

  typedef struct packed {
    logic [WORD_W-1:0] code;
    logic              descramble;
  } pbcs_cfg_t;

  typedef struct packed {
    logic [WORD_W-1:0] key;
    logic [CNT_W-1:0]  cnt;
    logic [CNT_W-1:0]  slot;
  } pbcs_chain_t;

  typedef struct packed {
    logic [WORD_W-1:0] w3;
    logic [WORD_W-1:0] w2;
    logic [WORD_W-1:0] w1;
    logic [WORD_W-1:0] w0;
    logic [IDX_W-1:0]  chain_index;
    logic [IDX_W-1:0]  page_slot;
    logic              last;
  } pbcs_result_t;

  function automatic logic [WORD_W-1:0] bit_rev(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] r;
    for (int b = 0; b < WORD_W; b++) begin
      r[b] = v[WORD_W-1-b];
    end
    return r;
  endfunction

endpackage

/* design/pbcs_apb_regs.sv */
// APB register file: scramble code and descramble mode.
module pbcs_apb_regs
  import pbcs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  output pbcs_cfg_t             cfg
);

  logic [WORD_W-1:0] code_r;
  logic              mode_r;
  logic              wr_en;
  pbcs_reg_t         sel;

  // word-aligned decode, byte lanes ignored
  assign sel        = pbcs_reg_t'(cfg_paddr[2]);
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_r <= '0;
      mode_r <= 1'b0;
    end else if (wr_en) begin
      case (sel)
        REG_SCRAMBLE_CODE:   code_r <= cfg_pwdata;
        REG_DESCRAMBLE_MODE: mode_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_SCRAMBLE_CODE:   cfg_prdata = code_r;
      REG_DESCRAMBLE_MODE: cfg_prdata = {{(CFG_DATA_W-1){1'b0}}, mode_r};
      default:             cfg_prdata = '0;
    endcase
  end

  assign cfg.code       = code_r;
  assign cfg.descramble = mode_r;

endmodule

/* design/pbcs_block_mix.sv */
// Block mixing, key seeding and next chain state for one 16-byte block.
module pbcs_block_mix
  import pbcs_pkg::*;
(
  input  logic [IN_DATA_W-1:0] blk,
  input  pbcs_cfg_t            cfg,
  input  pbcs_chain_t          cur,
  output pbcs_result_t         res,
  output pbcs_chain_t          nxt
);

  logic [WORD_W-1:0] a0, a1, a2, a3, page;
  logic [WORD_W-1:0] code, seed_key, key, mix, stored3;
  logic [WORD_W-1:0] r0, r1, r2, r3;
  logic [WORD_W-1:0] page_x;
  logic [CNT_W-1:0]  slot;
  logic              first, last;

  assign a0   = blk[WORD_W-1:0];
  assign a1   = blk[2*WORD_W-1:WORD_W];
  assign a2   = blk[3*WORD_W-1:2*WORD_W];
  assign a3   = blk[4*WORD_W-1:3*WORD_W];
  assign page = blk[5*WORD_W-1:4*WORD_W];

  // code rotated right by 21
  assign code     = {cfg.code[20:0], cfg.code[31:21]};
  // rotr(page,17) ^ code*7
  assign seed_key = {page[16:0], page[31:17]} ^ ((code << 3) - code);
  assign page_x   = page ^ code;

  assign first = (cur.cnt == '0);
  assign key   = first ? seed_key : cur.key;
  assign slot  = first ? CNT_W'(page_x[IDX_W-1:0]) : cur.slot;
  assign last  = (cur.cnt == CNT_W'(BLOCKS_PER_PAGE - 1));

  always_comb begin
    if (!cfg.descramble) begin
      r0      = a0 + key;
      mix     = r0 ^ a1;
      r1      = a1 + r0;
      r2      = a2 + mix;
      r3      = a3 + mix - a2;
      stored3 = r3;
    end else begin
      r0      = a0 - key;
      r1      = a1 - a0;
      mix     = a0 ^ r1;
      r2      = a2 - mix;
      r3      = a3 - (mix - r2);
      stored3 = a3;
    end
  end

  assign res.w0          = r0;
  assign res.w1          = r1;
  assign res.w2          = r2;
  assign res.w3          = r3;
  assign res.chain_index = cur.cnt[IDX_W-1:0];
  assign res.page_slot   = slot[IDX_W-1:0];
  assign res.last        = last;

  assign nxt.key  = bit_rev(stored3 + code);
  assign nxt.cnt  = last ? '0 : cur.cnt + CNT_W'(1);
  assign nxt.slot = (slot == CNT_W'(BLOCKS_PER_PAGE - 1)) ? '0 : slot + CNT_W'(1);

endmodule

/* design/page_block_chain_scrambler_unit.sv */
// Top level: page block chain scrambler with stream ports and APB registers.
//
// Takes one 16-byte block per clock while out_tready is high and returns it
// scrambled or descrambled, with its chain index, its rotated page slot and a
// last-block flag on tlast. An accepted block passes through the input
// register, then the result register, before it is valid on the output.
// The chain key, block counter and slot update in the mix logic on the
// same cycle a block moves into the result register, so back-to-back
// blocks of a page chain correctly. The first block after reset or after
// a last block reseeds key and slot from page_number. Write the registers
// only while no block is in flight.
`include "page_block_chain_scrambler_unit_defines.svh"

module page_block_chain_scrambler_unit
  import pbcs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // in_word0, in_word1, in_word2, in_word3, page_number (lowest bit up)
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // out_word0, out_word1, out_word2, out_word3, chain_index, page_slot, zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  // last_block
  output logic                  out_tlast,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  pbcs_cfg_t            cfg;
  pbcs_chain_t          chain_r, chain_nxt;
  pbcs_result_t         res;
  logic [IN_DATA_W-1:0] s1_data_r;
  logic                 s1_valid_r, s1_valid_nxt;
  pbcs_result_t         s2_res_r;
  logic                 s2_valid_r, s2_valid_nxt;
  logic                 in_acc, xfer;

  pbcs_apb_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  pbcs_block_mix u_mix (
    .blk (s1_data_r),
    .cfg (cfg),
    .cur (chain_r),
    .res (res),
    .nxt (chain_nxt)
  );

  assign xfer      = s1_valid_r && (!s2_valid_r || out_tready);
  assign in_tready = !s1_valid_r || xfer;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (xfer) begin
      s1_valid_nxt = 1'b0;
    end
    s2_valid_nxt = s2_valid_r;
    if (xfer) begin
      s2_valid_nxt = 1'b1;
    end else if (out_tready) begin
      s2_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      chain_r    <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
      if (xfer) begin
        chain_r <= chain_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r <= in_tdata;
    end
    if (xfer) begin
      s2_res_r <= res;
    end
  end

  assign out_tvalid = s2_valid_r;
  assign out_tlast  = s2_res_r.last;
  assign out_tdata  = OUT_DATA_W'({s2_res_r.page_slot, s2_res_r.chain_index,
                                   s2_res_r.w3, s2_res_r.w2, s2_res_r.w1,
                                   s2_res_r.w0});

  `PBCS_ASSERT_IMPLY(a_ready_only_when_room, clk, rst_n, !in_tready, s1_valid_r && s2_valid_r && !out_tready)
  `PBCS_ASSERT_NEXT(a_last_wraps_counter, clk, rst_n, xfer && res.last, chain_r.cnt == '0)
  `PBCS_ASSERT_NEXT(a_counter_steps, clk, rst_n, xfer && !res.last, chain_r.cnt == $past(chain_r.cnt) + CNT_W'(1))
  `PBCS_ASSERT_IMPLY(a_slot_in_page, clk, rst_n, 1'b1, chain_r.slot <= CNT_W'(BLOCKS_PER_PAGE - 1))

endmodule
